FILE: sv/lvp_pkg.sv
// ----------------------------------------------------------------------------
// lvp_pkg
// shared types and constants for the label vertical placement block
// ----------------------------------------------------------------------------
package lvp_pkg;

    localparam int TableDepth  = 64;
    localparam int SlotW       = 6;
    localparam int WindowLines = 100;
    localparam int LineW       = 7;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_MOVE   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_BAD    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_KEPT   = 2'd0,
        ST_MOVED  = 2'd1,
        ST_NORUN  = 2'd2,
        ST_ERROR  = 2'd3
    } status_t;

endpackage

FILE: sv/lvp_store.sv
// ----------------------------------------------------------------------------
// lvp_store
// box table: one write port and one registered read port
// ----------------------------------------------------------------------------
module lvp_store
    import lvp_pkg::*;
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [SlotW-1:0]        waddr,
    input  logic signed [15:0]      wleft,
    input  logic signed [15:0]      wtop,
    input  logic [11:0]             wcols,
    input  logic [6:0]              wrows,
    input  logic [SlotW-1:0]        raddr,
    output logic signed [15:0]      rleft,
    output logic signed [15:0]      rtop,
    output logic [11:0]             rcols,
    output logic [6:0]              rrows
);

    logic [50:0] mem [TableDepth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wleft, wtop, wcols, wrows};
        end
        {rleft, rtop, rcols, rrows} <= mem[raddr];
    end

endmodule

FILE: sv/label_vertical_placement.sv
// ----------------------------------------------------------------------------
// label_vertical_placement
// places a text box vertically so it avoids overlapping boxes
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; exactly one result
// beat follows, flagged by done for one cycle, and cannot be stalled. Add and
// move first read the slot, then stream the 64 table entries through the
// single registered read port and mark the 100-line window, then check the
// wanted lines, write the entry and give the done beat. When the wanted lines
// are busy, an upward and a downward free-run scan and a choice between their
// results come before the write. Remove and slot errors end once the slot is
// read. busy stays high meanwhile.
module label_vertical_placement
    import lvp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          action,
    input  logic [5:0]          entry_slot,
    input  logic signed [15:0]  new_x,
    input  logic signed [15:0]  new_y,
    input  logic [11:0]         box_width,
    input  logic [6:0]          box_height,
    output logic                done,
    output logic signed [15:0]  placed_y,
    output logic [1:0]          status
);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_SCAN, S_CHECK, S_UP, S_DOWN, S_DECIDE, S_WRITE
    } state_t;

    state_t state_reg;
    logic [TableDepth-1:0] valid_reg;
    logic [WindowLines-1:0] busy_line_reg;
    action_t act_reg;
    logic [SlotW-1:0] slot_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [11:0] w_reg;
    logic [6:0] h_reg;
    logic [SlotW:0] k_reg;
    logic k_v_reg;
    logic [SlotW-1:0] k_prev_reg;
    logic [LineW:0] i_reg;
    logic [LineW-1:0] run_reg;
    logic [LineW:0] up_reg, down_reg;
    logic up_ok_reg, down_ok_reg;
    logic done_reg;
    logic done_next;
    logic signed [15:0] placed_reg;
    status_t status_reg;

    logic signed [15:0] rleft, rtop;
    logic [11:0] rcols;
    logic [6:0] rrows;
    logic [SlotW-1:0] raddr;
    logic we;
    logic signed [15:0] wtop;

    lvp_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (slot_reg),
        .wleft (x_reg),
        .wtop  (wtop),
        .wcols (w_reg),
        .wrows (h_reg),
        .raddr (raddr),
        .rleft (rleft),
        .rtop  (rtop),
        .rcols (rcols),
        .rrows (rrows)
    );

    // effective height and wanted offset
    logic [LineW-1:0] hp;
    logic [LineW-1:0] want;
    assign hp   = (h_reg > 7'(WindowLines)) ? 7'(WindowLines) : h_reg;
    assign want = 7'((WindowLines - 32'(hp)) >> 1);

    logic signed [17:0] base;
    assign base = 18'(y_reg) - 18'(want);

    // marking of one stored box
    logic signed [17:0] xr, bl_end, from_s, to_s, from_c, to_c;
    logic hit;
    logic [WindowLines-1:0] mark;
    always_comb
    begin
        xr     = 18'(x_reg) + 18'(w_reg) - 18'sd1;
        bl_end = 18'(rleft) + 18'(rcols);
        from_s = 18'(rtop) - base;
        to_s   = from_s + 18'(rrows) - 18'sd1;
        hit    = k_v_reg && valid_reg[k_prev_reg] && (k_prev_reg != slot_reg)
                 && (18'(rleft) <= xr) && (bl_end > 18'(x_reg))
                 && !(to_s < 0) && !(from_s >= 18'(WindowLines));
        from_c = (from_s < 0) ? 18'sd0 : from_s;
        to_c   = (to_s >= 18'(WindowLines)) ? 18'(WindowLines - 1) : to_s;
        mark   = '0;
        for (int j = 0; j < WindowLines; j++)
        begin
            if (hit && 18'(j) >= from_c && 18'(j) <= to_c)
            begin
                mark[j] = 1'b1;
            end
        end
    end

    logic wanted_busy;
    always_comb
    begin
        wanted_busy = 1'b0;
        for (int j = 0; j < WindowLines; j++)
        begin
            if (32'(j) >= 32'(want) && 32'(j) < 32'(want) + 32'(hp) && busy_line_reg[j])
            begin
                wanted_busy = 1'b1;
            end
        end
    end

    logic slot_ok;
    always_comb
    begin
        case (act_reg)
            ACT_ADD:    slot_ok = !valid_reg[slot_reg];
            ACT_MOVE:   slot_ok = valid_reg[slot_reg];
            ACT_REMOVE: slot_ok = valid_reg[slot_reg];
            default:    slot_ok = 1'b0;
        endcase
    end

    logic signed [17:0] dist_up, dist_dn;
    assign dist_up = 18'(want) - 18'(up_reg);
    assign dist_dn = 18'(down_reg) - 18'(want);

    assign done_next = (state_reg == S_WRITE)
                       || ((state_reg == S_READ) && (!slot_ok || act_reg == ACT_REMOVE));

    assign raddr = (state_reg == S_IDLE) ? entry_slot : k_reg[SlotW-1:0];
    assign we    = (state_reg == S_WRITE);
    assign wtop  = placed_reg;
    assign busy  = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign placed_y = placed_reg;
    assign status   = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            k_v_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        act_reg  <= action_t'(action);
                        slot_reg <= entry_slot;
                        x_reg    <= new_x;
                        y_reg    <= new_y;
                        w_reg    <= box_width;
                        h_reg    <= box_height;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // stored entry for this slot is on the read port now
                    if (!slot_ok)
                    begin
                        placed_reg <= y_reg;
                        status_reg <= ST_ERROR;
                        state_reg  <= S_IDLE;
                    end
                    else if (act_reg == ACT_REMOVE)
                    begin
                        placed_reg <= rtop;
                        status_reg <= ST_KEPT;
                        valid_reg[slot_reg] <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if (act_reg == ACT_MOVE)
                        begin
                            w_reg <= rcols;
                            h_reg <= rrows;
                        end
                        busy_line_reg <= '0;
                        k_reg   <= '0;
                        k_v_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    busy_line_reg <= busy_line_reg | mark;
                    k_prev_reg <= k_reg[SlotW-1:0];
                    k_v_reg    <= !k_reg[SlotW];
                    k_reg      <= k_reg + 1'b1;
                    if (k_reg[SlotW] && !k_v_reg)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    placed_reg <= y_reg;
                    status_reg <= ST_KEPT;
                    if (hp == '0 || !wanted_busy)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        up_ok_reg   <= 1'b0;
                        down_ok_reg <= 1'b0;
                        run_reg     <= '0;
                        i_reg       <= 8'(want) + 8'(hp) - 8'd2;
                        state_reg   <= S_UP;
                    end
                end
                S_UP:
                begin
                    if (i_reg[LineW] || up_ok_reg)
                    begin
                        run_reg   <= '0;
                        i_reg     <= 8'(want) + 8'd1;
                        state_reg <= S_DOWN;
                    end
                    else
                    begin
                        if (busy_line_reg[i_reg[LineW-1:0]])
                        begin
                            run_reg <= '0;
                        end
                        else
                        begin
                            run_reg <= run_reg + 1'b1;
                            if (run_reg + 1'b1 == hp)
                            begin
                                up_ok_reg <= 1'b1;
                                up_reg    <= i_reg;
                            end
                        end
                        i_reg <= i_reg - 1'b1;
                    end
                end
                S_DOWN:
                begin
                    if (i_reg >= 8'(WindowLines) || down_ok_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        if (busy_line_reg[i_reg[LineW-1:0]])
                        begin
                            run_reg <= '0;
                        end
                        else
                        begin
                            run_reg <= run_reg + 1'b1;
                            if (run_reg + 1'b1 == hp)
                            begin
                                down_ok_reg <= 1'b1;
                                down_reg    <= i_reg - 8'(hp) + 8'd1;
                            end
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    if (!up_ok_reg && !down_ok_reg)
                    begin
                        status_reg <= ST_NORUN;
                    end
                    else
                    begin
                        status_reg <= ST_MOVED;
                        if (!up_ok_reg || (down_ok_reg && dist_up > dist_dn))
                        begin
                            placed_reg <= 16'(18'(y_reg) + dist_dn);
                        end
                        else
                        begin
                            placed_reg <= 16'(18'(y_reg) - dist_up);
                        end
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy with result");
    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> valid_reg[$past(slot_reg)])
        else $error("written slot not valid");
`endif

endmodule
